FILE: rtl/met_pkg.sv
// Shared types, constants and helpers for the escape-time evaluator.
// Used by every module under rtl; depends on nothing.
`default_nettype none

package met_pkg;

    localparam int FRAC_BITS  = 44;
    localparam int COORD_BITS = 12;
    localparam int VAL_BITS   = 48;
    localparam int ZOOM_W     = 47;
    localparam int DIM_W      = 13;
    localparam int CNT_W      = 16;
    localparam int CFG_W      = 48;
    localparam int CFG_IDX_W  = 3;

    localparam int HALF_W = VAL_BITS / 2;
    localparam int HI_W   = VAL_BITS - HALF_W;
    localparam int PP_W   = 2 * HALF_W;
    localparam int SQ_W   = 2 * VAL_BITS;
    localparam int MAG_W  = (2 * VAL_BITS + 1 > 2 * FRAC_BITS + 3) ?
                            2 * VAL_BITS + 1 : 2 * FRAC_BITS + 3;
    localparam int SAT_W  = MAG_W + 1;

    localparam int D_W    = ((COORD_BITS + 1 > DIM_W) ? COORD_BITS + 1 : DIM_W) + 1;
    localparam int ABS_W  = D_W - 1;
    localparam int FP_W   = ABS_W + HALF_W;
    localparam int PROD_W = ABS_W + ZOOM_W;

    localparam int QUEUE_DEPTH = 2;

    localparam int IN_W  = ((2 * COORD_BITS + 7) / 8) * 8;
    localparam int OUT_W = ((CNT_W + 7) / 8) * 8;

    localparam logic [ZOOM_W-1:0] ZOOM_RST   = 47'd70368744177;
    localparam logic [DIM_W-1:0]  WIDTH_RST  = 13'd1024;
    localparam logic [DIM_W-1:0]  HEIGHT_RST = 13'd768;
    localparam logic [CNT_W-1:0]  LIMIT_RST  = 16'd256;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ZOOM,
        REG_CENTER_RE,
        REG_CENTER_IM,
        REG_WIDTH,
        REG_HEIGHT,
        REG_LIMIT
    } t_reg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SUM,
        ST_UPD,
        ST_DONE
    } t_iter_state;

    typedef struct packed {
        logic        [ZOOM_W-1:0]   zoom;
        logic signed [VAL_BITS-1:0] center_re;
        logic signed [VAL_BITS-1:0] center_im;
        logic        [DIM_W-1:0]    width;
        logic        [DIM_W-1:0]    height;
        logic        [CNT_W-1:0]    limit;
    } t_cfg;

    typedef struct packed {
        logic signed [VAL_BITS-1:0] c_im;
        logic signed [VAL_BITS-1:0] c_re;
    } t_coord;

    // clamp a wide signed value into the signed VAL_BITS range
    function automatic logic signed [VAL_BITS-1:0] sat_val(
        input logic signed [SAT_W-1:0] a
    );
        logic [SAT_W-VAL_BITS:0] top;
        top = a[SAT_W-1:VAL_BITS-1];
        if ((&top) || !(|top)) begin
            return a[VAL_BITS-1:0];
        end else if (a[SAT_W-1]) begin
            return {1'b1, {(VAL_BITS-1){1'b0}}};
        end else begin
            return {1'b0, {(VAL_BITS-1){1'b1}}};
        end
    endfunction

endpackage

`default_nettype wire

FILE: rtl/mandelbrot_escape_time.sv
// Escape-time evaluator, top level. Holds the configuration registers and
// joins met_front, met_queue and met_iter; uses met_pkg.
// Input stream: one transaction per pixel, tdata = {pixel_y, pixel_x}.
// Output stream: one transaction per pixel, tdata = escape_count, in order.
// Configuration: i_cfg_we writes register i_cfg_idx (0 zoom_step,
// 1 center_real, 2 center_imag, 3 frame width, 4 frame height,
// 5 iteration_limit); write only while no pixel is in flight.
// The front end maps a pixel to c through its partial-product and
// signed-product registers and hands it to a 2-entry queue, so it keeps
// taking pixels while the iterator is busy. The iterator runs each round
// through ST_MUL, ST_SUM and ST_UPD on its multiplier set; a pixel runs r
// rounds (its count plus one, none for a zero limit), and the iterator
// takes the next pixel only after it has handed over the last count.
// A finished count sits in the output register while the receiver stalls;
// the iterator then waits with the next count, and the queue and front end
// fill and finally drop s_axis_tready.
// Synchronous reset empties all stages and restores the register defaults.
`default_nettype none

module mandelbrot_escape_time (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [met_pkg::IN_W-1:0]      s_axis_tdata,  // pixel_x, pixel_y
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic [met_pkg::OUT_W-1:0]          m_axis_tdata,  // escape_count
    input  wire logic                          i_cfg_we,
    input  wire logic [met_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [met_pkg::CFG_W-1:0]     i_cfg_data
);
    import met_pkg::*;

    t_cfg   r_cfg, n_cfg;
    t_coord front_data, q_data;
    logic   front_valid, front_ready, q_valid, q_ready;
    logic [CNT_W-1:0] count;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_idx))
                REG_ZOOM:      n_cfg.zoom      = i_cfg_data[ZOOM_W-1:0];
                REG_CENTER_RE: n_cfg.center_re = i_cfg_data[VAL_BITS-1:0];
                REG_CENTER_IM: n_cfg.center_im = i_cfg_data[VAL_BITS-1:0];
                REG_WIDTH:     n_cfg.width     = i_cfg_data[DIM_W-1:0];
                REG_HEIGHT:    n_cfg.height    = i_cfg_data[DIM_W-1:0];
                REG_LIMIT:     n_cfg.limit     = i_cfg_data[CNT_W-1:0];
                default: begin
                    n_cfg = r_cfg;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.zoom      <= ZOOM_RST;
            r_cfg.center_re <= '0;
            r_cfg.center_im <= '0;
            r_cfg.width     <= WIDTH_RST;
            r_cfg.height    <= HEIGHT_RST;
            r_cfg.limit     <= LIMIT_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    met_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_pixel_x   (s_axis_tdata[COORD_BITS-1:0]),
        .i_pixel_y   (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
        .i_cfg       (r_cfg),
        .o_out_valid (front_valid),
        .i_out_ready (front_ready),
        .o_out       (front_data)
    );

    met_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .o_push_ready (front_ready),
        .i_push_data  (front_data),
        .o_pop_valid  (q_valid),
        .i_pop_ready  (q_ready),
        .o_pop_data   (q_data)
    );

    met_iter u_iter (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .o_q_ready (q_ready),
        .i_q_data  (q_data),
        .i_limit   (r_cfg.limit),
        .o_m_valid (m_axis_tvalid),
        .i_m_ready (m_axis_tready),
        .o_m_count (count)
    );

    assign m_axis_tdata = OUT_W'(count);

endmodule

`default_nettype wire

FILE: rtl/met_front.sv
// Front end: takes pixel transactions and maps them onto the complex plane.
// Two registered stages (partial products, signed product); uses met_pkg.
`default_nettype none

module met_front (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire logic [met_pkg::COORD_BITS-1:0] i_pixel_x,
    input  wire logic [met_pkg::COORD_BITS-1:0] i_pixel_y,
    input  wire met_pkg::t_cfg                  i_cfg,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output met_pkg::t_coord                     o_out
);
    import met_pkg::*;

    logic              r_s1_valid, n_s1_valid;
    logic              r_s2_valid, n_s2_valid;
    logic              r_xneg, r_yneg;
    logic [FP_W-1:0]   r_x_pl, r_x_ph, r_y_pl, r_y_ph;
    logic signed [PROD_W:0] r_x_prod, r_y_prod;

    logic signed [D_W-1:0]  dx, dy;
    logic [ABS_W-1:0]       ax, ay;
    logic [FP_W-1:0]        zlo, zhi;
    logic [PROD_W-1:0]      mx, my;
    logic [PROD_W:0]        sx, sy;
    logic signed [PROD_W:0] shx, shy;
    logic signed [SAT_W-1:0] sum_x, sum_y;
    logic                   in_take, s2_load, push;

    always_comb begin
        push       = r_s2_valid && i_out_ready;
        s2_load    = r_s1_valid && (!r_s2_valid || push);
        o_in_ready = !r_s1_valid || s2_load;
        in_take    = i_in_valid && o_in_ready;

        n_s1_valid = in_take || (r_s1_valid && !s2_load);
        n_s2_valid = s2_load || (r_s2_valid && !push);

        dx  = D_W'({i_pixel_x, 1'b0}) - D_W'(i_cfg.width);
        dy  = D_W'({i_pixel_y, 1'b0}) - D_W'(i_cfg.height);
        ax  = dx[D_W-1] ? ABS_W'(-dx) : ABS_W'(dx);
        ay  = dy[D_W-1] ? ABS_W'(-dy) : ABS_W'(dy);
        zlo = FP_W'(i_cfg.zoom[HALF_W-1:0]);
        zhi = FP_W'(i_cfg.zoom[ZOOM_W-1:HALF_W]);

        mx = (PROD_W'(r_x_ph) << HALF_W) + PROD_W'(r_x_pl);
        my = (PROD_W'(r_y_ph) << HALF_W) + PROD_W'(r_y_pl);
        sx = r_xneg ? (~{1'b0, mx} + 1'b1) : {1'b0, mx};
        sy = r_yneg ? (~{1'b0, my} + 1'b1) : {1'b0, my};

        shx   = r_x_prod >>> 1;
        shy   = r_y_prod >>> 1;
        sum_x = SAT_W'(shx) + SAT_W'($signed(i_cfg.center_re));
        sum_y = SAT_W'(shy) + SAT_W'($signed(i_cfg.center_im));

        o_out_valid = r_s2_valid;
        o_out.c_re  = sat_val(sum_x);
        o_out.c_im  = sat_val(sum_y);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
            r_s2_valid <= n_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_xneg <= dx[D_W-1];
            r_yneg <= dy[D_W-1];
            r_x_pl <= FP_W'(ax) * zlo;
            r_x_ph <= FP_W'(ax) * zhi;
            r_y_pl <= FP_W'(ay) * zlo;
            r_y_ph <= FP_W'(ay) * zhi;
        end
        if (s2_load) begin
            r_x_prod <= sx;
            r_y_prod <= sy;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/met_queue.sv
// Short register queue of plane coordinates between front end and iterator.
// Depth from met_pkg::QUEUE_DEPTH; uses met_pkg.
`default_nettype none

module met_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push_valid,
    output logic                 o_push_ready,
    input  wire met_pkg::t_coord i_push_data,
    output logic                 o_pop_valid,
    input  wire logic            i_pop_ready,
    output met_pkg::t_coord      o_pop_data
);
    import met_pkg::*;

    localparam int QP_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    t_coord          r_mem [QUEUE_DEPTH];
    logic [QP_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QP_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QP_W:0]   r_count, n_count;
    logic            push, pop;

    always_comb begin
        o_push_ready = r_count != (QP_W + 1)'(QUEUE_DEPTH);
        o_pop_valid  = r_count != '0;
        o_pop_data   = r_mem[r_rd_ptr];
        push         = i_push_valid && o_push_ready;
        pop          = o_pop_valid && i_pop_ready;

        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == QP_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == QP_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        n_count = r_count + (QP_W + 1)'(push) - (QP_W + 1)'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/met_iter.sv
// Back end: runs z = z^2 + c for one point at a time; each round goes through
// partial products, square sums, then escape test and update; uses met_pkg.
`default_nettype none

module met_iter (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_q_valid,
    output logic                           o_q_ready,
    input  wire met_pkg::t_coord           i_q_data,
    input  wire logic [met_pkg::CNT_W-1:0] i_limit,
    output logic                           o_m_valid,
    input  wire logic                      i_m_ready,
    output logic [met_pkg::CNT_W-1:0]      o_m_count
);
    import met_pkg::*;

    localparam logic [MAG_W-1:0] FOUR_Q = MAG_W'(1) << (2 * FRAC_BITS + 2);

    function automatic logic [PP_W-1:0] umul(
        input logic [HALF_W-1:0] a,
        input logic [HALF_W-1:0] b
    );
        return PP_W'(a) * PP_W'(b);
    endfunction

    t_iter_state r_state, n_state;
    logic        r_out_valid, n_out_valid;
    logic [CNT_W-1:0] r_out_cnt, n_out_cnt;

    logic signed [VAL_BITS-1:0] r_zr, n_zr, r_zi, n_zi, r_cr, n_cr, r_ci, n_ci;
    logic [CNT_W-1:0] r_k, n_k, r_res, n_res;
    logic [PP_W-1:0]  r_rr_ll, n_rr_ll, r_rr_hl, n_rr_hl, r_rr_hh, n_rr_hh;
    logic [PP_W-1:0]  r_ii_ll, n_ii_ll, r_ii_hl, n_ii_hl, r_ii_hh, n_ii_hh;
    logic [PP_W-1:0]  r_ri_ll, n_ri_ll, r_ri_lh, n_ri_lh;
    logic [PP_W-1:0]  r_ri_hl, n_ri_hl, r_ri_hh, n_ri_hh;
    logic             r_ri_neg, n_ri_neg;
    logic [SQ_W-1:0]  r_r2, n_r2, r_i2, n_i2;
    logic signed [MAG_W-1:0] r_pri, n_pri;

    logic [VAL_BITS-1:0] ar, ai;
    logic [HALF_W-1:0]   ar_lo, ar_hi, ai_lo, ai_hi;
    logic [SQ_W-1:0]     pri_mag;
    logic [MAG_W-1:0]    pm, mag;
    logic signed [MAG_W-1:0] diff;
    logic signed [SAT_W-1:0] sum_r, sum_i;
    logic                escape, last;

    always_comb begin
        ar    = r_zr[VAL_BITS-1] ? (~r_zr + 1'b1) : r_zr;
        ai    = r_zi[VAL_BITS-1] ? (~r_zi + 1'b1) : r_zi;
        ar_lo = ar[HALF_W-1:0];
        ar_hi = HALF_W'(ar[VAL_BITS-1:HALF_W]);
        ai_lo = ai[HALF_W-1:0];
        ai_hi = HALF_W'(ai[VAL_BITS-1:HALF_W]);

        pri_mag = (SQ_W'(r_ri_hh) << (2 * HALF_W))
                + ((SQ_W'(r_ri_hl) + SQ_W'(r_ri_lh)) << HALF_W)
                + SQ_W'(r_ri_ll);
        pm = MAG_W'(pri_mag);

        mag    = MAG_W'(r_r2) + MAG_W'(r_i2);
        escape = mag > FOUR_Q;
        diff   = MAG_W'(r_r2) - MAG_W'(r_i2);
        sum_r  = SAT_W'(diff >>> FRAC_BITS) + SAT_W'(r_cr);
        sum_i  = SAT_W'(r_pri >>> (FRAC_BITS - 1)) + SAT_W'(r_ci);
        last   = ({1'b0, r_k} + 1'b1) == {1'b0, i_limit};

        n_state     = r_state;
        n_out_valid = r_out_valid && !i_m_ready;
        n_out_cnt   = r_out_cnt;
        o_q_ready   = 1'b0;
        n_zr = r_zr;  n_zi = r_zi;  n_cr = r_cr;  n_ci = r_ci;
        n_k  = r_k;   n_res = r_res;
        n_rr_ll = r_rr_ll;  n_rr_hl = r_rr_hl;  n_rr_hh = r_rr_hh;
        n_ii_ll = r_ii_ll;  n_ii_hl = r_ii_hl;  n_ii_hh = r_ii_hh;
        n_ri_ll = r_ri_ll;  n_ri_lh = r_ri_lh;
        n_ri_hl = r_ri_hl;  n_ri_hh = r_ri_hh;
        n_ri_neg = r_ri_neg;
        n_r2 = r_r2;  n_i2 = r_i2;  n_pri = r_pri;

        unique case (r_state)
            ST_IDLE: begin
                o_q_ready = 1'b1;
                if (i_q_valid) begin
                    n_cr  = $signed(i_q_data.c_re);
                    n_ci  = $signed(i_q_data.c_im);
                    n_zr  = $signed(i_q_data.c_re);
                    n_zi  = $signed(i_q_data.c_im);
                    n_k   = '0;
                    n_res = i_limit - 1'b1;
                    n_state = (i_limit == '0) ? ST_DONE : ST_MUL;
                end
            end
            ST_MUL: begin
                n_rr_ll  = umul(ar_lo, ar_lo);
                n_rr_hl  = umul(ar_hi, ar_lo);
                n_rr_hh  = umul(ar_hi, ar_hi);
                n_ii_ll  = umul(ai_lo, ai_lo);
                n_ii_hl  = umul(ai_hi, ai_lo);
                n_ii_hh  = umul(ai_hi, ai_hi);
                n_ri_ll  = umul(ar_lo, ai_lo);
                n_ri_lh  = umul(ar_lo, ai_hi);
                n_ri_hl  = umul(ar_hi, ai_lo);
                n_ri_hh  = umul(ar_hi, ai_hi);
                n_ri_neg = r_zr[VAL_BITS-1] ^ r_zi[VAL_BITS-1];
                n_state  = ST_SUM;
            end
            ST_SUM: begin
                n_r2 = (SQ_W'(r_rr_hh) << (2 * HALF_W))
                     + (SQ_W'(r_rr_hl) << (HALF_W + 1)) + SQ_W'(r_rr_ll);
                n_i2 = (SQ_W'(r_ii_hh) << (2 * HALF_W))
                     + (SQ_W'(r_ii_hl) << (HALF_W + 1)) + SQ_W'(r_ii_ll);
                n_pri   = r_ri_neg ? (~pm + 1'b1) : pm;
                n_state = ST_UPD;
            end
            ST_UPD: begin
                if (escape) begin
                    n_res   = r_k;
                    n_state = ST_DONE;
                end else begin
                    n_zr = sat_val(sum_r);
                    n_zi = sat_val(sum_i);
                    if (last) begin
                        n_res   = r_k;
                        n_state = ST_DONE;
                    end else begin
                        n_k     = r_k + 1'b1;
                        n_state = ST_MUL;
                    end
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_m_ready) begin
                    n_out_valid = 1'b1;
                    n_out_cnt   = r_res;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        o_m_valid = r_out_valid;
        o_m_count = r_out_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_cnt <= n_out_cnt;
        r_zr <= n_zr;  r_zi <= n_zi;  r_cr <= n_cr;  r_ci <= n_ci;
        r_k  <= n_k;   r_res <= n_res;
        r_rr_ll <= n_rr_ll;  r_rr_hl <= n_rr_hl;  r_rr_hh <= n_rr_hh;
        r_ii_ll <= n_ii_ll;  r_ii_hl <= n_ii_hl;  r_ii_hh <= n_ii_hh;
        r_ri_ll <= n_ri_ll;  r_ri_lh <= n_ri_lh;
        r_ri_hl <= n_ri_hl;  r_ri_hh <= n_ri_hh;
        r_ri_neg <= n_ri_neg;
        r_r2 <= n_r2;  r_i2 <= n_i2;  r_pri <= n_pri;
    end

endmodule

`default_nettype wire
